@@ rtl/linear_adrc_controller_macros.svh @@
// ----------------------------------------------------------------------------
// linear_adrc_controller_macros.svh
// Assertion helpers shared by the controller RTL.
// ----------------------------------------------------------------------------
`ifndef LINEAR_ADRC_CONTROLLER_MACROS_SVH
`define LINEAR_ADRC_CONTROLLER_MACROS_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define LAC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lac assertion failed");

// next-cycle implication
`define LAC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lac assertion failed");

`endif

@@ rtl/lac_pkg.sv @@
// ----------------------------------------------------------------------------
// lac_pkg
// Types, constants and the step program of the ADRC controller.
// ----------------------------------------------------------------------------
package lac_pkg;

  localparam int DW        = 32;       // state and drive width
  localparam int FW        = 16;       // fraction bits
  localparam int WW        = 64;       // intermediate width
  localparam int DIVW      = 32;       // divisor / remainder width
  localparam int DIV_STEPS = WW + FW;  // quotient bits produced
  localparam int CNT_W     = 7;
  localparam int TMP_W     = 3;
  localparam int NUM_TMP   = 8;
  localparam int NUM_INSTR = 41;
  localparam int PC_W      = 6;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRACK_GAIN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OBS_BW        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PLANT_GAIN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT   = 3'd4;

  localparam logic [TMP_W-1:0] T0 = 3'd0;
  localparam logic [TMP_W-1:0] T1 = 3'd1;
  localparam logic [TMP_W-1:0] T2 = 3'd2;
  localparam logic [TMP_W-1:0] T3 = 3'd3;
  localparam logic [TMP_W-1:0] T4 = 3'd4;
  localparam logic [TMP_W-1:0] T5 = 3'd5;
  localparam logic [TMP_W-1:0] T6 = 3'd6;
  localparam logic [TMP_W-1:0] T7 = 3'd7;

  localparam logic signed [WW-1:0] W_MAX = {1'b0, {(WW-1){1'b1}}};
  localparam logic signed [WW-1:0] W_MIN = {1'b1, {(WW-1){1'b0}}};

  typedef enum logic [1:0] {OP_ADD, OP_SUB, OP_MUL, OP_DIV} op_e;

  typedef enum logic [4:0] {
    SRC_ZERO, SRC_SP, SRC_Y, SRC_H, SRC_R, SRC_W0, SRC_WC, SRC_B0,
    SRC_V1, SRC_V2, SRC_Z1, SRC_Z2, SRC_Z3, SRC_UL,
    SRC_T0, SRC_T1, SRC_T2, SRC_T3, SRC_T4, SRC_T5, SRC_T6, SRC_T7
  } src_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_FETCH_A, ST_FETCH_B, ST_EXEC, ST_WAIT_MD, ST_CLAMP, ST_OUT
  } seq_state_e;

  typedef enum logic [2:0] {MD_IDLE, MD_MUL, MD_MFIN, MD_DIV, MD_DFIN} md_state_e;

  typedef struct packed {
    op_e              op;
    src_e             a;
    src_e             b;
    logic [TMP_W-1:0] dst;
    logic             dsat;  // saturate to DW instead of WW
  } instr_t;

  typedef struct packed {
    logic start;
    logic is_div;
  } md_req_t;

  function automatic instr_t mk(input op_e op, input src_e a, input src_e b,
                                input logic [TMP_W-1:0] dst, input logic dsat);
    instr_t i;
    i.op = op; i.a = a; i.b = b; i.dst = dst; i.dsat = dsat;
    return i;
  endfunction

  // one controller step; T0/T1 end as the new rate/value, T3/T5/T4 as the
  // new observer states, T2 as the quotient
  function automatic instr_t prog(input logic [PC_W-1:0] pc);
    instr_t i;
    case (pc)
      6'd0:  i = mk(OP_MUL, SRC_R,    SRC_R,  T0, 1'b0);
      6'd1:  i = mk(OP_SUB, SRC_V1,   SRC_SP, T1, 1'b0);
      6'd2:  i = mk(OP_MUL, SRC_T0,   SRC_T1, T0, 1'b0);
      6'd3:  i = mk(OP_SUB, SRC_ZERO, SRC_T0, T0, 1'b0);
      6'd4:  i = mk(OP_ADD, SRC_R,    SRC_R,  T1, 1'b0);
      6'd5:  i = mk(OP_MUL, SRC_T1,   SRC_V2, T1, 1'b0);
      6'd6:  i = mk(OP_SUB, SRC_T0,   SRC_T1, T0, 1'b0);
      6'd7:  i = mk(OP_MUL, SRC_V2,   SRC_H,  T1, 1'b0);
      6'd8:  i = mk(OP_ADD, SRC_V1,   SRC_T1, T1, 1'b1);
      6'd9:  i = mk(OP_MUL, SRC_T0,   SRC_H,  T0, 1'b0);
      6'd10: i = mk(OP_ADD, SRC_V2,   SRC_T0, T0, 1'b1);
      6'd11: i = mk(OP_SUB, SRC_Z1,   SRC_Y,  T2, 1'b0);
      6'd12: i = mk(OP_ADD, SRC_W0,   SRC_W0, T3, 1'b0);
      6'd13: i = mk(OP_ADD, SRC_T3,   SRC_W0, T3, 1'b0);
      6'd14: i = mk(OP_MUL, SRC_T3,   SRC_T2, T3, 1'b0);
      6'd15: i = mk(OP_SUB, SRC_Z2,   SRC_T3, T3, 1'b0);
      6'd16: i = mk(OP_MUL, SRC_T3,   SRC_H,  T3, 1'b0);
      6'd17: i = mk(OP_ADD, SRC_Z1,   SRC_T3, T3, 1'b1);
      6'd18: i = mk(OP_MUL, SRC_W0,   SRC_W0, T4, 1'b0);
      6'd19: i = mk(OP_ADD, SRC_T4,   SRC_T4, T5, 1'b0);
      6'd20: i = mk(OP_ADD, SRC_T5,   SRC_T4, T5, 1'b0);
      6'd21: i = mk(OP_MUL, SRC_T5,   SRC_T2, T5, 1'b0);
      6'd22: i = mk(OP_SUB, SRC_Z3,   SRC_T5, T5, 1'b0);
      6'd23: i = mk(OP_MUL, SRC_B0,   SRC_UL, T6, 1'b0);
      6'd24: i = mk(OP_ADD, SRC_T5,   SRC_T6, T5, 1'b0);
      6'd25: i = mk(OP_MUL, SRC_T5,   SRC_H,  T5, 1'b0);
      6'd26: i = mk(OP_ADD, SRC_Z2,   SRC_T5, T5, 1'b1);
      6'd27: i = mk(OP_MUL, SRC_T4,   SRC_W0, T4, 1'b0);
      6'd28: i = mk(OP_MUL, SRC_T4,   SRC_T2, T4, 1'b0);
      6'd29: i = mk(OP_SUB, SRC_ZERO, SRC_T4, T4, 1'b0);
      6'd30: i = mk(OP_MUL, SRC_T4,   SRC_H,  T4, 1'b0);
      6'd31: i = mk(OP_ADD, SRC_Z3,   SRC_T4, T4, 1'b1);
      6'd32: i = mk(OP_MUL, SRC_WC,   SRC_WC, T2, 1'b0);
      6'd33: i = mk(OP_SUB, SRC_T1,   SRC_T3, T6, 1'b0);
      6'd34: i = mk(OP_MUL, SRC_T2,   SRC_T6, T2, 1'b0);
      6'd35: i = mk(OP_SUB, SRC_T0,   SRC_T5, T6, 1'b0);
      6'd36: i = mk(OP_ADD, SRC_WC,   SRC_WC, T7, 1'b0);
      6'd37: i = mk(OP_MUL, SRC_T7,   SRC_T6, T6, 1'b0);
      6'd38: i = mk(OP_ADD, SRC_T2,   SRC_T6, T2, 1'b0);
      6'd39: i = mk(OP_SUB, SRC_T2,   SRC_T4, T2, 1'b0);
      6'd40: i = mk(OP_DIV, SRC_T2,   SRC_B0, T2, 1'b0);
      default: i = mk(OP_ADD, SRC_ZERO, SRC_ZERO, T0, 1'b0);
    endcase
    return i;
  endfunction

  // magnitude plus overflow flag and sign -> saturated wide value
  function automatic logic signed [WW-1:0] sat_mag(input logic neg, input logic over,
                                                   input logic [WW-1:0] m);
    logic signed [WW-1:0] r;
    if (neg) begin
      if (over || (m > W_MIN)) r = W_MIN;
      else r = $signed(-m);
    end else begin
      if (over || (m > W_MAX)) r = W_MAX;
      else r = $signed(m);
    end
    return r;
  endfunction

endpackage

@@ rtl/lac_muldiv.sv @@
// ----------------------------------------------------------------------------
// lac_muldiv
// Shared fixed-point multiply (four 32x32 passes) and restoring divide.
// ----------------------------------------------------------------------------
module lac_muldiv (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  lac_pkg::md_req_t               req_i,
  input  logic signed [lac_pkg::WW-1:0]  a_i,
  input  logic signed [lac_pkg::WW-1:0]  b_i,
  output logic                           done_o,
  output logic signed [lac_pkg::WW-1:0]  res_o
);
  import lac_pkg::*;

  localparam int PW = 2 * WW;
  localparam int SW = PW - FW;

  md_state_e            state_q, state_d;
  logic [CNT_W-1:0]     cnt_q;
  logic [WW-1:0]        ma_q, mb_q;
  logic                 neg_q, over_q, done_q;
  logic [PW-1:0]        acc_q;
  logic [WW+FW-1:0]     dvd_q;
  logic [DIVW-1:0]      den_q, rem_q;
  logic [WW-1:0]        quo_q;
  logic signed [WW-1:0] res_q;

  logic [WW/2-1:0] opa, opb;
  logic [WW-1:0]   pp;
  logic [6:0]      pp_sh;
  logic [SW-1:0]   shr;
  logic [DIVW:0]   r2, r2_sub;
  logic            ge, last_div;

  assign opa    = cnt_q[1] ? ma_q[WW-1:WW/2] : ma_q[WW/2-1:0];
  assign opb    = cnt_q[0] ? mb_q[WW-1:WW/2] : mb_q[WW/2-1:0];
  assign pp     = opa * opb;
  assign pp_sh  = {cnt_q[1] & cnt_q[0], cnt_q[1] ^ cnt_q[0], 5'd0};
  assign shr    = acc_q[PW-1:FW] + SW'(neg_q && (acc_q[FW-1:0] != '0));
  assign r2     = {rem_q, dvd_q[WW+FW-1]};
  assign r2_sub = r2 - {1'b0, den_q};
  assign ge     = r2 >= {1'b0, den_q};
  assign last_div = cnt_q == CNT_W'(DIV_STEPS - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= MD_IDLE;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      MD_IDLE: begin
        if (req_i.start) begin
          if (!req_i.is_div) state_d = MD_MUL;
          else if (a_i != '0 && b_i > 0) state_d = MD_DIV;
        end
      end
      MD_MUL:  if (cnt_q[1:0] == 2'd3) state_d = MD_MFIN;
      MD_MFIN: state_d = MD_IDLE;
      MD_DIV:  if (last_div) state_d = MD_DFIN;
      MD_DFIN: state_d = MD_IDLE;
      default: state_d = MD_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        MD_IDLE: begin
          cnt_q <= '0;
          // zero numerator and non-positive divisor finish at once
          if (req_i.start && req_i.is_div && !(a_i != '0 && b_i > 0)) done_q <= 1'b1;
        end
        MD_MUL:  cnt_q <= cnt_q + 1'b1;
        MD_DIV:  cnt_q <= cnt_q + 1'b1;
        MD_MFIN: done_q <= 1'b1;
        MD_DFIN: done_q <= 1'b1;
        default: cnt_q <= '0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      MD_IDLE: begin
        ma_q   <= a_i[WW-1] ? WW'(-a_i) : WW'(a_i);
        mb_q   <= b_i[WW-1] ? WW'(-b_i) : WW'(b_i);
        acc_q  <= '0;
        over_q <= 1'b0;
        quo_q  <= '0;
        rem_q  <= '0;
        den_q  <= b_i[DIVW-1:0];
        dvd_q  <= {(a_i[WW-1] ? WW'(-a_i) : WW'(a_i)), {FW{1'b0}}};
        if (req_i.start) begin
          neg_q <= req_i.is_div ? a_i[WW-1] : (a_i[WW-1] ^ b_i[WW-1]);
          if (req_i.is_div) begin
            if (a_i == '0) res_q <= '0;
            else if (!(b_i > 0)) res_q <= a_i[WW-1] ? W_MIN : W_MAX;
          end
        end
      end
      MD_MUL:  acc_q <= acc_q + ({{(PW-WW){1'b0}}, pp} << pp_sh);
      MD_MFIN: res_q <= sat_mag(neg_q, |shr[SW-1:WW], shr[WW-1:0]);
      MD_DIV: begin
        if (quo_q[WW-1]) over_q <= 1'b1;
        quo_q <= {quo_q[WW-2:0], ge};
        rem_q <= ge ? r2_sub[DIVW-1:0] : r2[DIVW-1:0];
        dvd_q <= {dvd_q[WW+FW-2:0], 1'b0};
      end
      MD_DFIN: res_q <= sat_mag(neg_q, over_q, quo_q);
      default: res_q <= res_q;
    endcase
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

@@ rtl/linear_adrc_controller.sv @@
// ----------------------------------------------------------------------------
// linear_adrc_controller
// Second-order linear ADRC: tracking differentiator, extended state
// observer and PD law with disturbance cancellation, Q16.16 fixed point.
// ----------------------------------------------------------------------------
// s_axis takes one item {measurement, setpoint}; m_axis returns one item per
// sample: the clamped drive in tdata, the clamp flag in tuser. The cfg
// channel writes the five gain/limit registers by index and is always ready.
// Write it only while no sample is in flight; the block does not enforce it.
// A sample runs a 41-step program through one ALU and one shared
// multiply/divide unit: each step fetches operand A, then operand B, then
// executes, an ALU step directly and a multiply (four 32x32 passes) or the
// divide (80 quotient bits) by waiting on the unit. A zero numerator or zero
// plant gain ends the divide at once. s_axis_tready is low from accept until
// the result loads and returns in the cycle after it.
// Reset clears filter, observer and last-drive state and loads the register
// defaults (h 0.05, r 20, w0 133, b0 8, limit 100).
// A stalled result waits in the output register; the next sample is taken
// meanwhile and its result is held until the slot frees.
// ----------------------------------------------------------------------------
module linear_adrc_controller (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [63:0]                     s_axis_tdata,   // setpoint, measurement
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [31:0]                     m_axis_tdata,   // drive
  output logic [0:0]                      m_axis_tuser,   // clamped
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [lac_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [31:0]                     cfg_data_i
);
  import lac_pkg::*;

  seq_state_e          state_q, state_d;
  logic [PC_W-1:0]     pc_q;
  instr_t              ins;

  logic [15:0]         h_q;
  logic [30:0]         r_q, w0_q, b0_q, lim_q;
  logic signed [DW-1:0] sp_q, y_q, v1_q, v2_q, z1_q, z2_q, z3_q, ul_q;
  logic signed [WW-1:0] tmp_q [NUM_TMP];
  logic signed [WW-1:0] a_q, b_q, src_val;
  src_e                sel;

  logic signed [WW-1:0] bn, alu_w, wr_data;
  logic signed [WW:0]   sum;
  logic                wr_en, last_ins, is_md, out_load;
  md_req_t             md_req;
  logic                md_done;
  logic signed [WW-1:0] md_res;

  logic signed [WW-1:0] lim_w, q_w, drive_w;
  logic signed [DW-1:0] drive_q, out_drive_q;
  logic                cut_q, out_cut_q, out_valid_q;

  assign ins      = prog(pc_q);
  assign is_md    = (ins.op == OP_MUL) || (ins.op == OP_DIV);
  assign last_ins = pc_q == PC_W'(NUM_INSTR - 1);

  // operand source
  assign sel = (state_q == ST_FETCH_A) ? ins.a : ins.b;
  always_comb begin
    case (sel)
      SRC_ZERO: src_val = '0;
      SRC_SP:   src_val = WW'(sp_q);
      SRC_Y:    src_val = WW'(y_q);
      SRC_H:    src_val = $signed({{(WW-16){1'b0}}, h_q});
      SRC_R:    src_val = $signed({{(WW-31){1'b0}}, r_q});
      SRC_W0:   src_val = $signed({{(WW-31){1'b0}}, w0_q});
      SRC_WC:   src_val = $signed({{(WW-29){1'b0}}, w0_q[30:2]});
      SRC_B0:   src_val = $signed({{(WW-31){1'b0}}, b0_q});
      SRC_V1:   src_val = WW'(v1_q);
      SRC_V2:   src_val = WW'(v2_q);
      SRC_Z1:   src_val = WW'(z1_q);
      SRC_Z2:   src_val = WW'(z2_q);
      SRC_Z3:   src_val = WW'(z3_q);
      SRC_UL:   src_val = WW'(ul_q);
      SRC_T0:   src_val = tmp_q[0];
      SRC_T1:   src_val = tmp_q[1];
      SRC_T2:   src_val = tmp_q[2];
      SRC_T3:   src_val = tmp_q[3];
      SRC_T4:   src_val = tmp_q[4];
      SRC_T5:   src_val = tmp_q[5];
      SRC_T6:   src_val = tmp_q[6];
      SRC_T7:   src_val = tmp_q[7];
      default:  src_val = '0;
    endcase
  end

  // saturating add/sub; negating the most negative value gives the maximum
  always_comb begin
    if (ins.op == OP_SUB) bn = (b_q == W_MIN) ? W_MAX : -b_q;
    else bn = b_q;
    sum = {a_q[WW-1], a_q} + {bn[WW-1], bn};
    if (sum[WW] != sum[WW-1]) alu_w = sum[WW] ? W_MIN : W_MAX;
    else alu_w = sum[WW-1:0];
    if (ins.dsat) begin
      if (alu_w > WW'(signed'({1'b0, {(DW-1){1'b1}}})))
        alu_w = WW'(signed'({1'b0, {(DW-1){1'b1}}}));
      else if (alu_w < WW'(signed'({1'b1, {(DW-1){1'b0}}})))
        alu_w = WW'(signed'({1'b1, {(DW-1){1'b0}}}));
    end
  end

  assign md_req.start  = (state_q == ST_EXEC) && is_md;
  assign md_req.is_div = ins.op == OP_DIV;

  lac_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req),
    .a_i    (a_q),
    .b_i    (b_q),
    .done_o (md_done),
    .res_o  (md_res)
  );

  assign wr_en   = ((state_q == ST_EXEC) && !is_md) || ((state_q == ST_WAIT_MD) && md_done);
  assign wr_data = (state_q == ST_WAIT_MD) ? md_res : alu_w;

  // drive clamp
  assign lim_w = $signed({{(WW-31){1'b0}}, lim_q});
  assign q_w   = tmp_q[2];
  always_comb begin
    if (q_w > lim_w) drive_w = lim_w;
    else if (q_w < -lim_w) drive_w = -lim_w;
    else drive_w = q_w;
  end

  assign out_load = (state_q == ST_OUT) && (!out_valid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:    if (s_axis_tvalid) state_d = ST_FETCH_A;
      ST_FETCH_A: state_d = ST_FETCH_B;
      ST_FETCH_B: state_d = ST_EXEC;
      ST_EXEC: begin
        if (is_md) state_d = ST_WAIT_MD;
        else state_d = last_ins ? ST_CLAMP : ST_FETCH_A;
      end
      ST_WAIT_MD: if (md_done) state_d = last_ins ? ST_CLAMP : ST_FETCH_A;
      ST_CLAMP:   state_d = ST_OUT;
      ST_OUT:     if (out_load) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= '0;
      out_valid_q <= 1'b0;
      h_q         <= 16'd3277;
      r_q         <= 31'd1310720;
      w0_q        <= 31'd8716288;
      b0_q        <= 31'd524288;
      lim_q       <= 31'd6553600;
      v1_q        <= '0;
      v2_q        <= '0;
      z1_q        <= '0;
      z2_q        <= '0;
      z3_q        <= '0;
      ul_q        <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_SAMPLE_PERIOD: h_q   <= cfg_data_i[15:0];
          REG_TRACK_GAIN:    r_q   <= cfg_data_i[30:0];
          REG_OBS_BW:        w0_q  <= cfg_data_i[30:0];
          REG_PLANT_GAIN:    b0_q  <= cfg_data_i[30:0];
          REG_DRIVE_LIMIT:   lim_q <= cfg_data_i[30:0];
          default: ;
        endcase
      end
      if (state_q == ST_IDLE) pc_q <= '0;
      else if (wr_en && !last_ins) pc_q <= pc_q + 1'b1;
      if (out_load) begin
        out_valid_q <= 1'b1;
        v1_q <= tmp_q[1][DW-1:0];
        v2_q <= tmp_q[0][DW-1:0];
        z1_q <= tmp_q[3][DW-1:0];
        z2_q <= tmp_q[5][DW-1:0];
        z3_q <= tmp_q[4][DW-1:0];
        ul_q <= drive_q;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_IDLE) && s_axis_tvalid) begin
      sp_q <= s_axis_tdata[31:0];
      y_q  <= s_axis_tdata[63:32];
    end
    if (state_q == ST_FETCH_A) a_q <= src_val;
    if (state_q == ST_FETCH_B) b_q <= src_val;
    if (wr_en) tmp_q[ins.dst] <= wr_data;
    if (state_q == ST_CLAMP) begin
      drive_q <= drive_w[DW-1:0];
      cut_q   <= drive_w != q_w;
    end
    if (out_load) begin
      out_drive_q <= drive_q;
      out_cut_q   <= cut_q;
    end
  end

  assign s_axis_tready = state_q == ST_IDLE;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_drive_q;
  assign m_axis_tuser  = out_cut_q;
  assign cfg_ready_o   = 1'b1;

  logic signed [WW-1:0] out_drive_w;
  assign out_drive_w = WW'(out_drive_q);

`include "linear_adrc_controller_macros.svh"

  `LAC_ASSERT_IMPL(a_md_done_in_wait, md_done, state_q == ST_WAIT_MD)
  `LAC_ASSERT_IMPL(a_pc_in_range, state_q != ST_IDLE, pc_q < PC_W'(NUM_INSTR))
  `LAC_ASSERT_NEXT(a_out_load_shows, out_load, m_axis_tvalid && s_axis_tready)
  `LAC_ASSERT_IMPL(a_drive_in_limit, m_axis_tvalid, (out_drive_w <= lim_w) && (out_drive_w >= -lim_w))

endmodule

@@ sim/linear_adrc_controller_tb.sv @@
// ----------------------------------------------------------------------------
// linear_adrc_controller_tb
// Streams setpoint/measurement items through the ADRC controller under
// changing gain settings and checks every drive item against a bit-exact
// fixed-point model of the differentiator, observer and PD law.
// ----------------------------------------------------------------------------
module linear_adrc_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lac_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 400;
  localparam int PHASES         = 10;
  localparam int PHASE_ITEMS    = 130;

  typedef struct packed {
    logic [31:0] drive;
    logic        clamped;
  } drive_item_t;

  typedef struct {
    logic [31:0] sp;
    logic [31:0] y;
    bit          typed;
    drive_item_t want;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;     // setpoint, measurement
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;          // drive
  logic [0:0]  m_axis_tuser;          // clamped
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  linear_adrc_controller DUT (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------- fixed-point drive predictor ----------------
  longint h_reg, r_reg, w0_reg, b0_reg, lim_reg;
  longint v1, v2, z1, z2, z3, u_last;

  function automatic longint lmax(int bits);
    return (bits >= 64) ? 64'sh7fff_ffff_ffff_ffff : (64'sd1 <<< (bits - 1)) - 1;
  endfunction

  function automatic longint lmin(int bits);
    return -lmax(bits) - 1;
  endfunction

  function automatic longint clampw(logic signed [64:0] v, int bits);
    if (v > lmax(bits)) return lmax(bits);
    if (v < lmin(bits)) return lmin(bits);
    return longint'(v);
  endfunction

  function automatic longint sadd(longint a, longint b, int bits);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    return clampw(s, bits);
  endfunction

  function automatic longint ssub(longint a, longint b, int bits);
    longint nb;
    nb = (b == lmin(64)) ? lmax(64) : -b;
    return sadd(a, nb, bits);
  endfunction

  function automatic longint sat_signed(bit neg, bit over, logic [63:0] m, int bits);
    logic [63:0] mx;
    mx = lmax(bits);
    if (neg) begin
      if (over || m > mx + 64'd1) return lmin(bits);
      return longint'(-m);
    end
    if (over || m > mx) return lmax(bits);
    return longint'(m);
  endfunction

  function automatic longint fmul(longint a, longint b, int bits);
    bit           neg;
    logic [63:0]  ma, mb;
    logic [127:0] p, q;
    neg = (a < 0) != (b < 0);
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    p = {64'd0, ma} * {64'd0, mb};
    q = p >> FW;
    if (neg && p[FW-1:0] != 0) q = q + 128'd1;   // floor for negatives
    return sat_signed(neg, q[127:64] != 0, q[63:0], bits);
  endfunction

  function automatic longint fdiv(longint num, longint den, int bits);
    bit           neg;
    logic [63:0]  m;
    logic [127:0] q;
    neg = num < 0;
    if (num == 0) return 0;
    if (den <= 0) return neg ? lmin(bits) : lmax(bits);
    m = neg ? -num : num;
    q = {48'd0, m, 16'd0} / {64'd0, den};
    return sat_signed(neg, q[127:64] != 0, q[63:0], bits);
  endfunction

  function automatic drive_item_t adrc_step(logic [31:0] sp_bits, logic [31:0] y_bits);
    longint sp, y, fh, nv1, nv2, e, b1, w0sq, b2, b3, nz1, nz2, nz3, t;
    longint wc, kp, kd, u0, q, drv;
    drive_item_t res;
    sp = longint'($signed(sp_bits));
    y  = longint'($signed(y_bits));
    fh = ssub(0, fmul(fmul(r_reg, r_reg, 64), ssub(v1, sp, 64), 64), 64);
    fh = ssub(fh, fmul(sadd(r_reg, r_reg, 64), v2, 64), 64);
    nv1 = sadd(v1, fmul(v2, h_reg, 64), 32);
    nv2 = sadd(v2, fmul(fh, h_reg, 64), 32);
    e = ssub(z1, y, 64);
    b1 = sadd(sadd(w0_reg, w0_reg, 64), w0_reg, 64);
    w0sq = fmul(w0_reg, w0_reg, 64);
    b2 = sadd(sadd(w0sq, w0sq, 64), w0sq, 64);
    b3 = fmul(w0sq, w0_reg, 64);
    t = ssub(z2, fmul(b1, e, 64), 64);
    nz1 = sadd(z1, fmul(t, h_reg, 64), 32);
    t = sadd(ssub(z3, fmul(b2, e, 64), 64), fmul(b0_reg, u_last, 64), 64);
    nz2 = sadd(z2, fmul(t, h_reg, 64), 32);
    t = ssub(0, fmul(b3, e, 64), 64);
    nz3 = sadd(z3, fmul(t, h_reg, 64), 32);
    v1 = nv1; v2 = nv2; z1 = nz1; z2 = nz2; z3 = nz3;
    wc = w0_reg >>> 2;
    kp = fmul(wc, wc, 64);
    kd = sadd(wc, wc, 64);
    u0 = sadd(fmul(kp, ssub(nv1, nz1, 64), 64), fmul(kd, ssub(nv2, nz2, 64), 64), 64);
    q = fdiv(ssub(u0, nz3, 64), b0_reg, 64);
    drv = q;
    if (drv > lim_reg) drv = lim_reg;
    else if (drv < -lim_reg) drv = -lim_reg;
    drv = clampw(65'(drv), 32);
    u_last = drv;
    res.drive = drv[31:0];
    res.clamped = (drv != q);
    return res;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    case (idx)
      REG_SAMPLE_PERIOD: h_reg   = longint'(val[15:0]);
      REG_TRACK_GAIN:    r_reg   = longint'(val[30:0]);
      REG_OBS_BW:        w0_reg  = longint'(val[30:0]);
      REG_PLANT_GAIN:    b0_reg  = longint'(val[30:0]);
      REG_DRIVE_LIMIT:   lim_reg = longint'(val[30:0]);
      default: ;
    endcase
  endfunction

  // ---------------- stimulus and checking ----------------
  drive_item_t pending_drives[$];
  int  err_cnt = 0;
  int  idle_cycles = 0;
  bit  gaps_on = 1'b1;

  task automatic send_sample(logic [31:0] sp, logic [31:0] y, bit typed, drive_item_t want);
    int gap;
    drive_item_t pred;
    gap = gaps_on ? $urandom_range(0, 10) : 0;
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {y, sp};
    do @(posedge clk_i); while (!s_axis_tready);
    pred = adrc_step(sp, y);
    pending_drives.push_back(typed ? want : pred);
  endtask

  task automatic settle;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_drives.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [31:0] rand_q;
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 3))
      0: v = {{12{v[19]}}, v[19:0]};      // within +-8
      1: v = {{8{v[23]}}, v[23:0]};
      2: v = v[0] ? 32'h7fff_ffff - v[3:0] : 32'h8000_0000 + v[3:0];
      default: ;
    endcase
    return v;
  endfunction

  task automatic random_settings;
    bit full;
    full = ($urandom_range(0, 3) == 0);
    write_reg(REG_SAMPLE_PERIOD, full ? $urandom : $urandom_range(1, 6554));
    write_reg(REG_TRACK_GAIN,    full ? $urandom : $urandom_range(0, 50 << 16));
    write_reg(REG_OBS_BW,        full ? $urandom : $urandom_range(0, 200 << 16));
    write_reg(REG_PLANT_GAIN,    full ? $urandom : $urandom_range(1, 20 << 16));
    write_reg(REG_DRIVE_LIMIT,   full ? $urandom : $urandom_range(0, 200 << 16));
    if ($urandom_range(0, 2) == 0)
      write_reg(CFG_IDX_W'($urandom_range(5, 7)), $urandom);
  endtask

  stim_row_t rows[$];
  drive_item_t zero_item;

  initial begin
    zero_item = '0;
    h_reg = 3277; r_reg = 1310720; w0_reg = 8716288; b0_reg = 524288; lim_reg = 6553600;
    v1 = 0; v2 = 0; z1 = 0; z2 = 0; z3 = 0; u_last = 0;
    // all-zero state and input: every term vanishes
    rows.push_back('{32'h0, 32'h0, 1'b1, zero_item});
    rows.push_back('{32'h0001_0000, 32'h0, 1'b0, zero_item});
    rows.push_back('{32'h7fff_ffff, 32'h0, 1'b0, zero_item});
    rows.push_back('{32'h8000_0000, 32'h0, 1'b0, zero_item});
    rows.push_back('{32'h0, 32'h7fff_ffff, 1'b0, zero_item});
    rows.push_back('{32'h0, 32'h8000_0000, 1'b0, zero_item});
    rows.push_back('{32'h7fff_ffff, 32'h8000_0000, 1'b0, zero_item});
    rows.push_back('{32'h8000_0000, 32'h7fff_ffff, 1'b0, zero_item});
    rows.push_back('{32'hffff_ffff, 32'h0000_0001, 1'b0, zero_item});
    rows.push_back('{32'h0000_8000, 32'hffff_8000, 1'b0, zero_item});

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (rows[i]) send_sample(rows[i].sp, rows[i].y, rows[i].typed, rows[i].want);
    settle();

    // upper extremes, zero plant gain (quotient saturates), wide limit
    write_reg(REG_SAMPLE_PERIOD, 32'hffff_ffff);
    write_reg(REG_TRACK_GAIN,    32'hffff_ffff);
    write_reg(REG_OBS_BW,        32'h7fff_ffff);
    write_reg(REG_PLANT_GAIN,    32'h0);
    write_reg(REG_DRIVE_LIMIT,   32'h7fff_ffff);
    for (int i = 2; i < 6; i++) send_sample(rows[i].sp, rows[i].y, 1'b0, zero_item);
    settle();

    // lower extremes: minimal gains, zero limit, unused indexes ignored
    write_reg(REG_SAMPLE_PERIOD, 32'h1);
    write_reg(REG_TRACK_GAIN,    32'h0);
    write_reg(REG_OBS_BW,        32'h0);
    write_reg(REG_PLANT_GAIN,    32'h1);
    write_reg(REG_DRIVE_LIMIT,   32'h0);
    write_reg(CFG_IDX_W'(5), 32'hffff_ffff);
    write_reg(CFG_IDX_W'(7), 32'h0);
    for (int i = 4; i < 9; i++) send_sample(rows[i].sp, rows[i].y, 1'b0, zero_item);
    settle();

    for (int p = 0; p < PHASES; p++) begin
      random_settings();
      gaps_on = (p % 3 != 1);
      for (int i = 0; i < PHASE_ITEMS; i++)
        send_sample(rand_q(), rand_q(), 1'b0, zero_item);
      settle();
    end

    if (err_cnt == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  // receiver: random stall before each item while gaps are on
  initial begin
    int n;
    forever begin
      n = gaps_on ? $urandom_range(0, 10) : 0;
      repeat (n) begin
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
      end
      @(negedge clk_i);
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  always @(posedge clk_i) begin
    drive_item_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_drives.size() == 0) begin
        $display("%0t: unexpected item drive=%h clamped=%b", $time, m_axis_tdata,
                 m_axis_tuser);
        err_cnt++;
      end else begin
        want = pending_drives.pop_front();
        if (m_axis_tdata !== want.drive) begin
          $display("%0t: drive expected %h actual %h", $time, want.drive, m_axis_tdata);
          err_cnt++;
        end
        if (m_axis_tuser[0] !== want.clamped) begin
          $display("%0t: clamped expected %b actual %b", $time, want.clamped,
                   m_axis_tuser[0]);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/lac_pkg.sv
rtl/lac_muldiv.sv
rtl/linear_adrc_controller.sv
sim/linear_adrc_controller_tb.sv
